// ----- rtl/sliding_row_window_min_max_assert.svh -----
// Assertion macros for the sliding row window min/max block.
// Used by the port checker; needs clk and arst_n in scope.
`ifndef SLIDING_ROW_WINDOW_MIN_MAX_ASSERT_SVH
`define SLIDING_ROW_WINDOW_MIN_MAX_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SWMM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/swmm_pkg.sv -----
// Shared types and constants for the sliding row window min/max block.
// No dependencies; imported by every RTL module.
package swmm_pkg;

	localparam int SMP_W       = 16;
	localparam int CFG_W       = 11;
	localparam int SLOT_OUT_W  = 6;
	localparam int ROWS_OUT_W  = 7;
	localparam int MAX_ROWS_DEF    = 64;
	localparam int ROW_LEN_MAX_DEF = 1024;
	localparam int ROW_LEN_RST     = 256;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_W     = 2;

	typedef logic signed [SMP_W-1:0] smp_t;

	localparam smp_t SMP_POS_MAX = 16'sh7fff;
	localparam smp_t SMP_NEG_MAX = 16'sh8000;

	// Extremes of one completed row
	typedef struct packed {
		smp_t lo;
		smp_t hi;
	} row_ext_t;

	// One result beat
	typedef struct packed {
		smp_t                  row_low;
		smp_t                  row_high;
		smp_t                  window_low;
		smp_t                  window_high;
		logic [SLOT_OUT_W-1:0] slot_written;
		logic [ROWS_OUT_W-1:0] rows_held;
		logic [SLOT_OUT_W-1:0] oldest_slot;
	} result_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_DRAIN,
		B_EMIT
	} back_state_t;

endpackage

// ----- rtl/sliding_row_window_min_max.sv -----
// Sliding row window min/max, top level.
// Input channel (in_valid / in_stall / sample): one sample per beat. Every
// row_length samples close a row; the row's extremes go into a ring of
// MAX_ROWS slots, overwriting the oldest once the ring is full.
// Output channel (out_valid / out_stall / fields): one beat per completed
// row with row and window extremes, slot written, row count, oldest slot.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes row_length;
// 0 acts as 1, values above ROW_LEN_MAX saturate. Write only when idle.
// Flow: the front end takes one sample per cycle while in_stall is low. The
// back end handles one row at a time: it pops the row and writes its slot,
// reads each filled slot through the single read port of the slot store,
// drains the read and loads the output, waiting while out_stall holds a beat.
// Completed rows wait in a 4-entry queue; in_stall rises when it is full.
// Reset clears the counters, the running extremes and the queue; row_length
// returns to 256. No clearing pass: only filled slots are ever scanned.
// A held output beat keeps its payload while out_stall is high.
module sliding_row_window_min_max #(
	parameter int MAX_ROWS    = swmm_pkg::MAX_ROWS_DEF,
	parameter int ROW_LEN_MAX = swmm_pkg::ROW_LEN_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [swmm_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [swmm_pkg::SMP_W-1:0] sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [swmm_pkg::SMP_W-1:0] row_low,
	output logic signed [swmm_pkg::SMP_W-1:0] row_high,
	output logic signed [swmm_pkg::SMP_W-1:0] window_low,
	output logic signed [swmm_pkg::SMP_W-1:0] window_high,
	output logic [swmm_pkg::SLOT_OUT_W-1:0]   slot_written,
	output logic [swmm_pkg::ROWS_OUT_W-1:0]   rows_held,
	output logic [swmm_pkg::SLOT_OUT_W-1:0]   oldest_slot
);
	import swmm_pkg::*;

	// front -> queue
	logic     push;
	row_ext_t push_row;
	logic     q_full;
	// queue -> back
	logic     pop;
	row_ext_t pop_row;
	logic     q_empty;
	result_t  res;

	swmm_front #(
		.ROW_LEN_MAX(ROW_LEN_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.q_full   (q_full),
		.push     (push),
		.push_row (push_row)
	);

	swmm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_row(push_row),
		.pop     (pop),
		.pop_row (pop_row),
		.full    (q_full),
		.empty   (q_empty)
	);

	swmm_back #(
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_row    (pop_row),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res      (res)
	);

	// result register fields straight to the ports
	assign row_low      = res.row_low;
	assign row_high     = res.row_high;
	assign window_low   = res.window_low;
	assign window_high  = res.window_high;
	assign slot_written = res.slot_written;
	assign rows_held    = res.rows_held;
	assign oldest_slot  = res.oldest_slot;

endmodule

// ----- rtl/swmm_front.sv -----
// Front end: takes samples, tracks the running row extremes and pushes
// each completed row into the row queue. Holds the row length register.
// Depends on swmm_pkg.
module swmm_front #(
	parameter int ROW_LEN_MAX = swmm_pkg::ROW_LEN_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [swmm_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  swmm_pkg::smp_t              sample,
	input  logic                        q_full,
	output logic                        push,
	output swmm_pkg::row_ext_t          push_row
);
	import swmm_pkg::*;

	localparam int LEN_W = $clog2(ROW_LEN_MAX + 1);
	localparam int POS_W = (ROW_LEN_MAX > 1) ? $clog2(ROW_LEN_MAX) : 1;
	localparam int CW    = (LEN_W > CFG_W) ? LEN_W : CFG_W;
	localparam int LEN_RST = (ROW_LEN_RST < ROW_LEN_MAX) ? ROW_LEN_RST : ROW_LEN_MAX;

	logic [LEN_W-1:0] len_q;
	logic [POS_W-1:0] pos_q;
	smp_t             run_lo_q;
	smp_t             run_hi_q;
	smp_t             s_lo;
	smp_t             s_hi;
	logic             accept;
	logic             row_done;
	logic [LEN_W-1:0] len_wr;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;

	// zero means one, too large saturates
	always_comb begin
		if (cfg_data == '0) begin
			len_wr = LEN_W'(1);
		end else if (CW'(cfg_data) > CW'(ROW_LEN_MAX)) begin
			len_wr = LEN_W'(ROW_LEN_MAX);
		end else begin
			len_wr = LEN_W'(cfg_data);
		end
	end

	always_comb begin
		s_lo     = (sample < run_lo_q) ? sample : run_lo_q;
		s_hi     = (sample > run_hi_q) ? sample : run_hi_q;
		row_done = (LEN_W'(pos_q) + LEN_W'(1)) >= len_q;
		push     = accept && row_done;
		push_row.lo = s_lo;
		push_row.hi = s_hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= LEN_W'(LEN_RST);
			pos_q    <= '0;
			run_lo_q <= SMP_POS_MAX;
			run_hi_q <= SMP_NEG_MAX;
		end else begin
			if (cfg_valid && cfg_ready) begin
				len_q <= len_wr;
			end
			if (accept) begin
				if (row_done) begin
					pos_q    <= '0;
					run_lo_q <= SMP_POS_MAX;
					run_hi_q <= SMP_NEG_MAX;
				end else begin
					pos_q    <= pos_q + POS_W'(1);
					run_lo_q <= s_lo;
					run_hi_q <= s_hi;
				end
			end
		end
	end

endmodule

// ----- rtl/swmm_queue.sv -----
// Short queue of completed-row extremes between front and back end.
// Depends on swmm_pkg.
module swmm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  swmm_pkg::row_ext_t push_row,
	input  logic               pop,
	output swmm_pkg::row_ext_t pop_row,
	output logic               full,
	output logic               empty
);
	import swmm_pkg::*;

	row_ext_t           ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full    = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_row = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (Q_PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/swmm_back.sv -----
// Back end: stores each row in the slot ring, rescans the filled slots
// for the window extremes and holds the result in an output register.
// Depends on swmm_pkg.
module swmm_back #(
	parameter int MAX_ROWS = swmm_pkg::MAX_ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  swmm_pkg::row_ext_t q_row,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output swmm_pkg::result_t  res
);
	import swmm_pkg::*;

	localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W = $clog2(MAX_ROWS + 1);

	back_state_t      state_q;
	back_state_t      state_nxt;
	row_ext_t         mem [MAX_ROWS];
	row_ext_t         rd_s1;
	logic             rd_vld_s1;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] wrap_q;
	logic [IDX_W-1:0] addr_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] wr_slot;
	logic [IDX_W-1:0] last_idx;
	logic [CNT_W-1:0] cnt_m1;
	row_ext_t         row_q;
	smp_t             wlo_q;
	smp_t             whi_q;
	logic             ring_full;
	logic             out_free;
	logic             scan_rd;
	logic             load_out;
	logic             out_valid_q;
	result_t          res_q;

	assign ring_full = (cnt_q == CNT_W'(MAX_ROWS));
	assign wr_slot   = ring_full ? wrap_q : cnt_q[IDX_W-1:0];
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign last_idx  = cnt_m1[IDX_W-1:0];
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			B_IDLE:  if (!q_empty) state_nxt = B_SCAN;
			B_SCAN:  if (addr_q == last_idx) state_nxt = B_DRAIN;
			B_DRAIN: state_nxt = B_EMIT;
			B_EMIT:  if (out_free) state_nxt = B_IDLE;
			default: state_nxt = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		scan_rd  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			B_IDLE:  pop = !q_empty;
			B_SCAN:  scan_rd = 1'b1;
			B_DRAIN: ;
			B_EMIT:  load_out = out_free;
			default: ;
		endcase
	end

	// slot store: written on pop, read once per scan cycle
	always_ff @(posedge clk) begin
		if (pop) begin
			mem[wr_slot] <= q_row;
		end
		rd_s1 <= mem[addr_q];
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			row_q  <= q_row;
			slot_q <= wr_slot;
			wlo_q  <= SMP_POS_MAX;
			whi_q  <= SMP_NEG_MAX;
		end else if (rd_vld_s1) begin
			if (rd_s1.lo < wlo_q) wlo_q <= rd_s1.lo;
			if (rd_s1.hi > whi_q) whi_q <= rd_s1.hi;
		end
		if (load_out) begin
			res_q.row_low      <= row_q.lo;
			res_q.row_high     <= row_q.hi;
			res_q.window_low   <= wlo_q;
			res_q.window_high  <= whi_q;
			res_q.slot_written <= SLOT_OUT_W'(slot_q);
			res_q.rows_held    <= ROWS_OUT_W'(cnt_q);
			res_q.oldest_slot  <= SLOT_OUT_W'(wrap_q);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			wrap_q      <= '0;
			addr_q      <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= scan_rd;
			if (pop) begin
				addr_q <= '0;
				if (ring_full) begin
					wrap_q <= (wrap_q == IDX_W'(MAX_ROWS - 1)) ? '0 : wrap_q + IDX_W'(1);
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if (scan_rd) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/swmm_checker.sv -----
// Port-level checker for the sliding row window min/max block, bound to
// the top level. Depends on swmm_pkg and sliding_row_window_min_max_assert.svh.
`include "sliding_row_window_min_max_assert.svh"

module swmm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [swmm_pkg::SMP_W-1:0] row_low,
	input logic signed [swmm_pkg::SMP_W-1:0] row_high,
	input logic signed [swmm_pkg::SMP_W-1:0] window_low,
	input logic signed [swmm_pkg::SMP_W-1:0] window_high
);
	import swmm_pkg::*;

	// a row always holds at least one sample
	`SWMM_ASSERT_NOW(a_row_order, out_valid, row_low <= row_high, "row_low above row_high")
	// the window contains the row just written
	`SWMM_ASSERT_NOW(a_win_low, out_valid, window_low <= row_low, "window_low above row_low")
	`SWMM_ASSERT_NOW(a_win_high, out_valid, window_high >= row_high, "window_high below row_high")
	// a stalled beat stays put
	`SWMM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(window_low) && $stable(row_low), "stalled output beat changed")

endmodule

bind sliding_row_window_min_max swmm_checker u_swmm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.row_low    (row_low),
	.row_high   (row_high),
	.window_low (window_low),
	.window_high(window_high)
);
